>>> rtl/paged_mmu_lru_frame_manager_core_assert.svh
// Assertion macros for the frame manager
`ifndef PAGED_MMU_LRU_FRAME_MANAGER_CORE_ASSERT_SVH
`define PAGED_MMU_LRU_FRAME_MANAGER_CORE_ASSERT_SVH
// implication checked on every clock, masked in reset
`define PMF_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
// next-cycle implication, masked in reset
`define PMF_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`endif

>>> rtl/pmf_pkg.sv
package pmf_pkg;
   localparam int unsigned DefProcs  = 16;
   localparam int unsigned DefPages  = 64;
   localparam int unsigned DefFrames = 64;

   localparam logic [1:0] CMD_ACCESS = 2'd0;
   localparam logic [1:0] CMD_TERM   = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;
   localparam logic [1:0] CMD_OWNER  = 2'd3;

   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_FAULT   = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_TERM    = 3'd3;
   localparam logic [2:0] ST_LOADED  = 3'd4;
   localparam logic [2:0] ST_NOFRAME = 3'd5;

   localparam logic [1:0] NTF_NONE  = 2'd0;
   localparam logic [1:0] NTF_FAULT = 2'd1;
   localparam logic [1:0] NTF_END   = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PTRD, S_PTWAIT, S_FREE, S_OWN, S_OWNCHK, S_OWNRES,
      S_FREESCAN, S_LRU, S_LRUWAIT, S_LRUDONE, S_COMMIT, S_DONE
   } state_type;
endpackage

>>> rtl/pmf_page_ram.sv
module pmf_page_ram
   import pmf_pkg::*;
#(
   parameter int unsigned Depth = DefProcs * DefPages,
   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [Aw-1:0] wr_addr,
   input  logic          wr_valid,
   input  logic [5:0]    wr_frame,
   input  logic [31:0]   wr_stamp,
   input  logic [Aw-1:0] rd_addr,
   output logic          rd_valid,
   output logic [5:0]    rd_frame,
   output logic [31:0]   rd_stamp
);
   logic [38:0] mem [Depth];
   logic [38:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_valid, wr_frame, wr_stamp};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_valid = rd_ff[38];
   assign rd_frame = rd_ff[37:32];
   assign rd_stamp = rd_ff[31:0];
endmodule

>>> rtl/paged_mmu_lru_frame_manager_core.sv
// Frame manager: one command at a time, busy high while it runs.
// A command is not taken until the one before it has finished; start is taken only
//   while busy is low.
// The result strobe rsp_valid is high one cycle; the receiver cannot stall.
// Reset (sync, active high): clock, counts cleared; busy while page/owner tables clear.
module paged_mmu_lru_frame_manager_core
   import pmf_pkg::*;
#(
   parameter int unsigned MaxProcs  = DefProcs,
   parameter int unsigned MaxPages  = DefPages,
   parameter int unsigned MaxFrames = DefFrames
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_frame_count,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_process,
   input  logic [6:0]  req_page,
   input  logic [6:0]  req_load_value,
   input  logic [5:0]  req_frame_index,
   input  logic        req_release_req,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_frame,
   output logic        rsp_evicted,
   output logic [5:0]  rsp_evicted_page,
   output logic [1:0]  rsp_notify,
   output logic [31:0] rsp_stamp
);
`include "paged_mmu_lru_frame_manager_core_assert.svh"

   localparam int unsigned Pw    = (MaxPages > 1) ? $clog2(MaxPages) : 1;
   localparam int unsigned Qw    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
   localparam int unsigned Fw    = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
   localparam int unsigned Depth = MaxProcs * MaxPages;
   localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned Cw    = $clog2(MaxPages + 1);   // page count width
   localparam int unsigned Nw    = $clog2(MaxFrames + 1);  // frame counter width
   localparam int unsigned Ow    = $clog2(MaxProcs + 1);   // owner code width
   // post-reset sweep length: covers every page entry and every owner slot
   localparam int unsigned Cl    = (Depth > MaxFrames) ? Depth : MaxFrames;
   localparam int unsigned Kw    = (Cl > 1) ? $clog2(Cl) : 1;

   state_type state_ff, state_in;

   // request latch
   logic [1:0]  cmd_ff;
   logic [3:0]  proc_ff;
   logic [6:0]  page_ff, load_ff;
   logic [5:0]  fidx_ff;
   logic        rel_ff;
   logic [6:0]  fcount_ff;
   logic [31:0] clock_ff, clock_in;

   // state tables: owner slots in a small memory with a registered read
   logic [Ow-1:0]    owner_mem [MaxFrames];
   logic [Ow-1:0]    own_rd_ff;
   logic [Cw-1:0]    count_ff [MaxProcs];
   logic [Kw-1:0]    clr_ff, clr_in;

   // scan counters: frame index i, page index j
   logic [Nw-1:0] fi_ff, fi_in;
   logic [Cw-1:0] pj_ff, pj_in;
   logic          any_ff, any_in, hit_ff, hit_in;
   logic [Pw-1:0] best_ff, best_in;
   logic [31:0]   bstamp_ff, bstamp_in;
   logic [5:0]    f_ff, f_in;

   // result
   logic        rv_ff, rv_in;
   logic [2:0]  st_ff, st_in;
   logic [5:0]  fr_ff, fr_in;
   logic        ev_ff, ev_in;
   logic [5:0]  evp_ff, evp_in;
   logic [1:0]  nt_ff, nt_in;

   // ram port
   logic          wr_en, wr_valid, rd_valid;
   logic [Aw-1:0] wr_addr, rd_addr;
   logic [5:0]    wr_frame, rd_frame;
   logic [31:0]   rd_stamp;
   logic [Aw-1:0] base;
   logic [Nw-1:0] nf;
   logic          pok;
   logic [Ow-1:0] own_code;
   logic [Cw-1:0] np;
   logic [Aw-1:0] ent;
   logic [Fw-1:0] fi_idx;
   logic [Aw-1:0] pj_addr;
   logic          accept;

   // frame-owner writes
   logic          own_clr, own_set;
   logic [Fw-1:0] own_idx;
   logic [Ow-1:0] own_val;
   logic          cnt_wr;

   pmf_page_ram #(.Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_valid(wr_valid),
      .wr_frame(wr_frame),
      .wr_stamp(clock_ff),
      .rd_addr (rd_addr),
      .rd_valid(rd_valid),
      .rd_frame(rd_frame),
      .rd_stamp(rd_stamp)
   );

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign pok    = ({28'd0, proc_ff} < 32'(MaxProcs));
   assign own_code = Ow'({1'b0, proc_ff} + 5'd1);
   assign np     = pok ? count_ff[proc_ff[Qw-1:0]] : '0;
   assign base   = Aw'(32'(proc_ff) * MaxPages);
   assign ent    = Aw'(32'(base) + 32'(page_ff));
   assign pj_addr = Aw'(32'(base) + 32'(pj_ff));
   assign fi_idx = fi_ff[Fw-1:0];
   assign nf     = (32'(fcount_ff) < MaxFrames) ? Nw'(fcount_ff) : Nw'(MaxFrames);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         clock_ff  <= '0;
         fcount_ff <= 7'd64;
         rv_ff     <= 1'b0;
         for (int k = 0; k < MaxProcs; k++)  count_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         clock_ff <= clock_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) fcount_ff <= csr_frame_count;
         if (cnt_wr) begin
            count_ff[proc_ff[Qw-1:0]] <= (32'(load_ff) < MaxPages) ?
               Cw'(load_ff) : Cw'(MaxPages);
         end
      end
   end

   // owner table; read address follows the next scan index so the data
   // for fi_ff is ready in the state that tests it
   always_ff @(posedge clock) begin
      if (own_clr || own_set) owner_mem[own_idx] <= own_val;
      own_rd_ff <= owner_mem[fi_in[Fw-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         proc_ff <= req_process;
         page_ff <= req_page;
         load_ff <= req_load_value;
         fidx_ff <= req_frame_index;
         rel_ff  <= req_release_req;
      end
      fi_ff <= fi_in;  pj_ff <= pj_in;  any_ff <= any_in;  hit_ff <= hit_in;
      best_ff <= best_in;  bstamp_ff <= bstamp_in;  f_ff <= f_in;
      st_ff <= st_in;  fr_ff <= fr_in;  ev_ff <= ev_in;  evp_ff <= evp_in;
      nt_ff <= nt_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      clock_in = clock_ff;
      fi_in = fi_ff;  pj_in = pj_ff;  any_in = any_ff;  hit_in = hit_ff;
      best_in = best_ff;  bstamp_in = bstamp_ff;  f_in = f_ff;
      rv_in = 1'b0;
      st_in = st_ff;  fr_in = fr_ff;  ev_in = ev_ff;  evp_in = evp_ff;  nt_in = nt_ff;
      wr_en = 1'b0;  wr_addr = ent;  wr_valid = 1'b1;  wr_frame = f_ff;  rd_addr = ent;
      own_clr = 1'b0;  own_set = 1'b0;  own_idx = fi_idx;  own_val = '0;
      cnt_wr = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // post-reset sweep: one page entry and one owner slot per cycle
            wr_en = 1'b1;  wr_addr = Aw'(clr_ff);  wr_valid = 1'b0;  wr_frame = '0;
            own_clr = 1'b1;  own_idx = clr_ff[Fw-1:0];  own_val = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == Kw'(Cl - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_PTRD;
               fi_in = '0;  pj_in = '0;  any_in = 1'b0;
               st_in = ST_LOADED;  fr_in = '0;  ev_in = 1'b0;  evp_in = '0;
               nt_in = NTF_NONE;
            end
         end
         S_PTRD: begin
            // decode; page-table entry read issued at ent
            case (cmd_ff)
               CMD_ACCESS: begin
                  if (!pok || ({25'd0, page_ff} >= 32'(np))) begin
                     st_in = ST_INVALID;  nt_in = NTF_END;
                     state_in = pok ? S_FREE : S_DONE;
                  end else begin
                     state_in = S_PTWAIT;
                  end
               end
               CMD_TERM: begin
                  st_in = ST_TERM;  nt_in = NTF_END;
                  state_in = pok ? S_FREE : S_DONE;
               end
               CMD_LOAD: begin
                  cnt_wr = pok;  state_in = S_DONE;
               end
               default: begin
                  if (pok && (32'(fidx_ff) < MaxFrames)) begin
                     own_set = 1'b1;  own_idx = fidx_ff[Fw-1:0];
                     own_val = rel_ff ? '0 : own_code;
                  end
                  state_in = S_DONE;
               end
            endcase
         end
         S_PTWAIT: begin
            // entry back: a valid page is a hit and gets a fresh stamp
            if (rd_valid) begin
               wr_en = 1'b1;  wr_frame = rd_frame;
               fr_in = rd_frame;  st_in = ST_HIT;
               clock_in = clock_ff + 32'd1;
               state_in = S_DONE;
            end else begin
               nt_in = NTF_FAULT;  state_in = S_OWN;
            end
         end
         S_FREE: begin
            if (fi_ff >= nf) begin
               state_in = S_DONE;
            end else begin
               if (own_rd_ff == own_code) own_clr = 1'b1;
               fi_in = fi_ff + 1'b1;
            end
         end
         S_OWN: begin
            // owned frame search, one frame per outer step
            if (fi_ff >= nf) begin
               fi_in = '0;  state_in = S_FREESCAN;
            end else if (own_rd_ff == own_code) begin
               pj_in = '0;  hit_in = 1'b0;  state_in = S_OWNCHK;
            end else begin
               fi_in = fi_ff + 1'b1;
            end
         end
         S_OWNCHK: begin
            // walk the page table for a valid page mapping frame fi
            rd_addr = pj_addr;
            if (pj_ff >= np || hit_ff) begin
               state_in = S_OWNRES;
            end else begin
               state_in = S_OWNRES;
               pj_in = pj_ff;
            end
         end
         S_OWNRES: begin
            // read data for pj_ff is now valid
            if (pj_ff >= np) begin
               if (!hit_ff) begin
                  f_in = 6'(fi_ff);  state_in = S_COMMIT;
               end else begin
                  fi_in = fi_ff + 1'b1;  state_in = S_OWN;
               end
            end else begin
               if (rd_valid && (rd_frame == 6'(fi_ff))) hit_in = 1'b1;
               if (rd_valid && (rd_frame == 6'(fi_ff))) begin
                  fi_in = fi_ff + 1'b1;  state_in = S_OWN;
               end else begin
                  pj_in = pj_ff + 1'b1;  state_in = S_OWNCHK;
               end
            end
         end
         S_FREESCAN: begin
            if (fi_ff >= nf) begin
               pj_in = '0;  any_in = 1'b0;  state_in = S_LRU;
            end else if (own_rd_ff == '0) begin
               own_set = 1'b1;  own_val = own_code;
               f_in = 6'(fi_ff);  state_in = S_COMMIT;
            end else begin
               fi_in = fi_ff + 1'b1;
            end
         end
         S_LRU: begin
            rd_addr = pj_addr;
            state_in = (pj_ff >= np) ? S_LRUDONE : S_LRUWAIT;
         end
         S_LRUWAIT: begin
            if (rd_valid && (!any_ff || rd_stamp < bstamp_ff)) begin
               any_in = 1'b1;  best_in = pj_ff[Pw-1:0];
               bstamp_in = rd_stamp;  f_in = rd_frame;
            end
            pj_in = pj_ff + 1'b1;  state_in = S_LRU;
         end
         S_LRUDONE: begin
            if (any_ff) begin
               // victim entry drops its valid bit
               wr_en = 1'b1;  wr_valid = 1'b0;
               wr_addr = Aw'(32'(base) + 32'(best_ff));
               ev_in = 1'b1;  evp_in = 6'(best_ff);
               state_in = S_COMMIT;
            end else begin
               st_in = ST_NOFRAME;  state_in = S_DONE;
            end
         end
         S_COMMIT: begin
            wr_en = 1'b1;
            st_in = ST_FAULT;  fr_in = f_ff;  state_in = S_DONE;
         end
         S_DONE: begin
            rv_in = 1'b1;  state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = st_ff;
   assign rsp_frame        = fr_ff;
   assign rsp_evicted      = ev_ff;
   assign rsp_evicted_page = evp_ff;
   assign rsp_notify       = nt_ff;
   assign rsp_stamp        = (rv_ff && st_ff == ST_HIT) ? clock_ff - 32'd1 : clock_ff;

   `PMF_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `PMF_ASSERT_NXT(a_start_busy, clock, reset, accept, busy)
   `PMF_ASSERT_IMP(a_evict_fault, clock, reset, rsp_valid && rsp_evicted, rsp_status == ST_FAULT)
endmodule
